>>> sv/hrbd_pkg.sv
// ---------------------------------------------------------------------------
// hrbd_pkg
// Shared types, constants and character helpers for the HTTP response body
// deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package hrbd_pkg;

  localparam int unsigned LEN_W      = 32;
  localparam int unsigned BODY_LEN_W = 32;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  localparam logic [8*14-1:0] CL_NAME  = "Content-Length";
  localparam logic [8*17-1:0] TE_NAME  = "Transfer-Encoding";
  localparam logic [8*8-1:0]  CK_VALUE = " chunked";

  localparam logic [4:0] CL_NAME_LEN  = 5'd14;
  localparam logic [4:0] TE_NAME_LEN  = 5'd17;
  localparam logic [3:0] CK_VALUE_LEN = 4'd8;
  localparam logic [4:0] NAME_POS_MAX = 5'd31;
  localparam logic [3:0] VAL_POS_MAX  = 4'd15;

  typedef enum logic [2:0] {
    PH_STATUS = 3'd0,
    PH_HEADER = 3'd1,
    PH_SIZE   = 3'd2,
    PH_BODY   = 3'd3,
    PH_CLOSE  = 3'd4,
    PH_DONE   = 3'd5
  } hrbd_phase_e;

  typedef enum logic [1:0] {
    NUM_IDLE   = 2'd0,
    NUM_PREFIX = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_DONE   = 2'd3
  } hrbd_num_e;

  typedef enum logic [1:0] {
    CLS_FIRST = 2'd0,
    CLS_CR_OK = 2'd1,
    CLS_BAD   = 2'd2
  } hrbd_close_e;

  typedef struct packed {
    logic                  body_valid;
    logic [7:0]            body_byte;
    logic [2:0]            byte_class;
    logic                  crlf_error;
    logic                  message_end;
    logic                  is_chunked;
    logic                  has_length;
    logic [BODY_LEN_W-1:0] body_length;
  } hrbd_result_t;

  function automatic logic is_blank(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] b);
    logic [3:0] v;
    if (is_digit(b)) begin
      v = b[3:0];
    end else begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic cl_match(logic [4:0] pos, logic [7:0] b);
    logic [8*14-1:0] s;
    s = CL_NAME << {pos, 3'b000};
    return (pos < CL_NAME_LEN) && (b == s[8*14-1 -: 8]);
  endfunction

  function automatic logic te_match(logic [4:0] pos, logic [7:0] b);
    logic [8*17-1:0] s;
    s = TE_NAME << {pos, 3'b000};
    return (pos < TE_NAME_LEN) && (b == s[8*17-1 -: 8]);
  endfunction

  function automatic logic ck_match(logic [3:0] pos, logic [7:0] b);
    logic [8*8-1:0] s;
    s = CK_VALUE << {pos, 3'b000};
    return (pos < CK_VALUE_LEN) && (b == s[8*8-1 -: 8]);
  endfunction

endpackage

`default_nettype wire

>>> sv/http_response_body_deframer.sv
// ---------------------------------------------------------------------------
// http_response_body_deframer
// Byte-stream HTTP/1.1 response deframer: header parse, chunked decoding,
// and length-delimited body extraction.
// ---------------------------------------------------------------------------
// Accepts one response byte per cycle while not stalled and returns one
// result per byte in the same order. Each byte passes through the input
// register, then the result register; throughput is one byte every
// cycle, set by the combinational parser step between the two registers.
// Backpressure on the result side stalls the input side only once both
// registers are full.
`default_nettype none

module http_response_body_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // [7:0] body_byte, [8] crlf_error,
                                            // [9] is_chunked, [10] has_length,
                                            // [42:11] body_length, [47:43] zero
  output logic [3:0]       m_axis_tuser_o,  // [0] body_valid, [3:1] byte_class
  output logic             m_axis_tlast_o   // message_end
);
  import hrbd_pkg::*;

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q;
  logic         out_valid_q, out_valid_d;
  hrbd_result_t out_q;
  hrbd_result_t step_res;
  logic         advance;
  logic         in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  hrbd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (step_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_q.body_length, out_q.has_length,
                            out_q.is_chunked, out_q.crlf_error, out_q.body_byte};
  assign m_axis_tuser_o  = {out_q.byte_class, out_q.body_valid};
  assign m_axis_tlast_o  = out_q.message_end;

endmodule

`default_nettype wire

>>> sv/hrbd_sat_mac.sv
// ---------------------------------------------------------------------------
// hrbd_sat_mac
// Saturating multiply-accumulate by ten or sixteen for number parsing.
// ---------------------------------------------------------------------------
`default_nettype none

module hrbd_sat_mac (
  input  wire logic [hrbd_pkg::LEN_W-1:0] acc_i,
  input  wire logic [3:0]                 digit_i,
  input  wire logic                       hex_i,
  output logic      [hrbd_pkg::LEN_W-1:0] acc_o
);
  import hrbd_pkg::*;

  logic [LEN_W+3:0] prod;
  logic [LEN_W+3:0] sum;

  always_comb begin
    if (hex_i) begin
      prod = {acc_i, 4'b0000};
    end else begin
      prod = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0};
    end
    sum = prod + (LEN_W + 4)'(digit_i);
    if (|sum[LEN_W+3:LEN_W]) begin
      acc_o = '1;
    end else begin
      acc_o = sum[LEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/hrbd_parser.sv
// ---------------------------------------------------------------------------
// hrbd_parser
// Parse state and single-byte step of the response deframer.
// ---------------------------------------------------------------------------
`default_nettype none

module hrbd_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [7:0]           byte_i,
  output hrbd_pkg::hrbd_result_t    res_o
);
  import hrbd_pkg::*;

  hrbd_phase_e       phase_q, phase_d;
  logic              pending_cr_q, pending_cr_d;
  logic              line_empty_q, line_empty_d;
  logic              after_colon_q, after_colon_d;
  logic [4:0]        name_pos_q, name_pos_d;
  logic              name_is_len_q, name_is_len_d;
  logic              name_is_enc_q, name_is_enc_d;
  logic [3:0]        value_pos_q, value_pos_d;
  logic              value_ck_q, value_ck_d;
  hrbd_num_e         num_stage_q, num_stage_d;
  logic [LEN_W-1:0]  num_acc_q, num_acc_d;
  logic [LEN_W-1:0]  decl_len_q, decl_len_d;
  logic              len_seen_q, len_seen_d;
  logic              chunked_q, chunked_d;
  logic [LEN_W-1:0]  remain_q, remain_d;
  hrbd_close_e       closing_q, closing_d;
  logic              last_chunk_q, last_chunk_d;
  logic [LEN_W-1:0]  total_q, total_d;

  logic [LEN_W-1:0]  mac_out;
  logic [3:0]        mac_digit;
  logic [LEN_W:0]    total_sum;
  logic [LEN_W-1:0]  remain_dec;
  logic              valid, err, done;

  assign mac_digit = (phase_q == PH_SIZE) ? hex_val(byte_i) : byte_i[3:0];
  assign total_sum = {1'b0, total_q} + {1'b0, num_acc_q};
  assign remain_dec = (remain_q != '0) ? remain_q - LEN_W'(1) : remain_q;

  hrbd_sat_mac u_mac (
    .acc_i   (num_acc_q),
    .digit_i (mac_digit),
    .hex_i   (phase_q == PH_SIZE),
    .acc_o   (mac_out)
  );

  always_comb begin
    phase_d       = phase_q;
    pending_cr_d  = pending_cr_q;
    line_empty_d  = line_empty_q;
    after_colon_d = after_colon_q;
    name_pos_d    = name_pos_q;
    name_is_len_d = name_is_len_q;
    name_is_enc_d = name_is_enc_q;
    value_pos_d   = value_pos_q;
    value_ck_d    = value_ck_q;
    num_stage_d   = num_stage_q;
    num_acc_d     = num_acc_q;
    decl_len_d    = decl_len_q;
    len_seen_d    = len_seen_q;
    chunked_d     = chunked_q;
    remain_d      = remain_q;
    closing_d     = closing_q;
    last_chunk_d  = last_chunk_q;
    total_d       = total_q;
    valid         = 1'b0;
    err           = 1'b0;
    done          = 1'b0;

    unique case (phase_q)
      PH_STATUS, PH_HEADER, PH_SIZE: begin
        if (byte_i == CH_LF && pending_cr_q) begin
          pending_cr_d  = 1'b0;
          line_empty_d  = 1'b1;
          after_colon_d = 1'b0;
          name_pos_d    = '0;
          name_is_len_d = 1'b1;
          name_is_enc_d = 1'b1;
          value_pos_d   = '0;
          value_ck_d    = 1'b1;
          num_stage_d   = NUM_IDLE;
          num_acc_d     = '0;
          if (phase_q == PH_STATUS) begin
            phase_d = PH_HEADER;
          end else if (phase_q == PH_HEADER) begin
            if (!line_empty_q) begin
              if (after_colon_q && name_is_len_q && name_pos_q == CL_NAME_LEN) begin
                decl_len_d = num_acc_q;
                len_seen_d = 1'b1;
              end
              if (after_colon_q && name_is_enc_q && name_pos_q == TE_NAME_LEN &&
                  value_ck_q && value_pos_q == CK_VALUE_LEN) begin
                chunked_d = 1'b1;
              end
            end else if (chunked_q) begin
              phase_d = PH_SIZE;
              total_d = '0;
            end else if (len_seen_q && decl_len_q != '0) begin
              remain_d = decl_len_q;
              phase_d  = PH_BODY;
            end else begin
              phase_d = PH_DONE;
              done    = 1'b1;
            end
          end else begin
            total_d   = total_sum[LEN_W] ? '1 : total_sum[LEN_W-1:0];
            closing_d = CLS_FIRST;
            if (num_acc_q == '0) begin
              last_chunk_d = 1'b1;
              phase_d      = PH_CLOSE;
            end else begin
              remain_d = num_acc_q;
              phase_d  = PH_BODY;
            end
          end
        end else begin
          // held CR turns out to be line content
          if (pending_cr_q) begin
            line_empty_d = 1'b0;
            if (phase_q == PH_HEADER && !after_colon_q) begin
              name_is_len_d = 1'b0;
              name_is_enc_d = 1'b0;
              if (name_pos_q < NAME_POS_MAX) begin
                name_pos_d = name_pos_q + 5'd1;
              end
            end else if (phase_q != PH_STATUS) begin
              if (phase_q == PH_HEADER) begin
                value_ck_d = 1'b0;
                if (value_pos_q < VAL_POS_MAX) begin
                  value_pos_d = value_pos_q + 4'd1;
                end
              end
              if (num_stage_q != NUM_IDLE) begin
                num_stage_d = NUM_DONE;
              end
            end
          end
          if (byte_i == CH_CR) begin
            pending_cr_d = 1'b1;
          end else begin
            pending_cr_d = 1'b0;
            line_empty_d = 1'b0;
            if (phase_q == PH_HEADER) begin
              if (!after_colon_d) begin
                if (byte_i == CH_COLON) begin
                  after_colon_d = 1'b1;
                end else begin
                  if (!cl_match(name_pos_d, byte_i)) name_is_len_d = 1'b0;
                  if (!te_match(name_pos_d, byte_i)) name_is_enc_d = 1'b0;
                  if (name_pos_d < NAME_POS_MAX) name_pos_d = name_pos_d + 5'd1;
                end
              end else begin
                if (!ck_match(value_pos_d, byte_i)) value_ck_d = 1'b0;
                if (value_pos_d < VAL_POS_MAX) value_pos_d = value_pos_d + 4'd1;
                unique case (num_stage_d)
                  NUM_IDLE: begin
                    if (is_blank(byte_i)) begin
                      num_stage_d = NUM_IDLE;
                    end else if (byte_i == CH_PLUS) begin
                      num_stage_d = NUM_DIGITS;
                    end else if (is_digit(byte_i)) begin
                      num_acc_d   = LEN_W'(byte_i[3:0]);
                      num_stage_d = NUM_DIGITS;
                    end else begin
                      num_stage_d = NUM_DONE;
                    end
                  end
                  NUM_DIGITS: begin
                    if (is_digit(byte_i)) begin
                      num_acc_d = mac_out;
                    end else begin
                      num_stage_d = NUM_DONE;
                    end
                  end
                  default: begin
                    num_stage_d = NUM_DONE;
                  end
                endcase
              end
            end else if (phase_q == PH_SIZE) begin
              unique case (num_stage_d)
                NUM_IDLE: begin
                  if (is_blank(byte_i)) begin
                    num_stage_d = NUM_IDLE;
                  end else if (byte_i == CH_ZERO) begin
                    num_acc_d   = '0;
                    num_stage_d = NUM_PREFIX;
                  end else if (is_hex(byte_i)) begin
                    num_acc_d   = LEN_W'(hex_val(byte_i));
                    num_stage_d = NUM_DIGITS;
                  end else begin
                    num_stage_d = NUM_DONE;
                  end
                end
                NUM_PREFIX, NUM_DIGITS: begin
                  if (num_stage_d == NUM_PREFIX &&
                      (byte_i == CH_X_LO || byte_i == CH_X_UP)) begin
                    num_stage_d = NUM_DIGITS;
                  end else if (is_hex(byte_i)) begin
                    num_acc_d   = mac_out;
                    num_stage_d = NUM_DIGITS;
                  end else begin
                    num_stage_d = NUM_DONE;
                  end
                end
                default: begin
                  num_stage_d = NUM_DONE;
                end
              endcase
            end
          end
        end
      end
      PH_BODY: begin
        valid    = 1'b1;
        remain_d = remain_dec;
        if (remain_dec == '0) begin
          if (chunked_q) begin
            phase_d   = PH_CLOSE;
            closing_d = CLS_FIRST;
          end else begin
            phase_d = PH_DONE;
            done    = 1'b1;
          end
        end
      end
      PH_CLOSE: begin
        if (closing_q == CLS_FIRST) begin
          closing_d = (byte_i == CH_CR) ? CLS_CR_OK : CLS_BAD;
        end else begin
          err       = (closing_q != CLS_CR_OK) || (byte_i != CH_LF);
          closing_d = CLS_FIRST;
          if (last_chunk_q) begin
            phase_d = PH_DONE;
            done    = 1'b1;
          end else begin
            phase_d       = PH_SIZE;
            pending_cr_d  = 1'b0;
            line_empty_d  = 1'b1;
            after_colon_d = 1'b0;
            name_pos_d    = '0;
            name_is_len_d = 1'b1;
            name_is_enc_d = 1'b1;
            value_pos_d   = '0;
            value_ck_d    = 1'b1;
            num_stage_d   = NUM_IDLE;
            num_acc_d     = '0;
          end
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    res_o.body_valid  = valid;
    res_o.body_byte   = valid ? byte_i : 8'h00;
    res_o.byte_class  = (phase_q == PH_STATUS || phase_q == PH_HEADER ||
                         phase_q == PH_SIZE || phase_q == PH_BODY ||
                         phase_q == PH_CLOSE) ? phase_q : PH_DONE;
    res_o.crlf_error  = err;
    res_o.message_end = done;
    res_o.is_chunked  = chunked_d;
    res_o.has_length  = len_seen_d;
    if (chunked_d) begin
      res_o.body_length = BODY_LEN_W'(total_d);
    end else if (len_seen_d) begin
      res_o.body_length = BODY_LEN_W'(decl_len_d);
    end else begin
      res_o.body_length = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_STATUS;
      pending_cr_q  <= 1'b0;
      line_empty_q  <= 1'b1;
      after_colon_q <= 1'b0;
      name_pos_q    <= '0;
      name_is_len_q <= 1'b1;
      name_is_enc_q <= 1'b1;
      value_pos_q   <= '0;
      value_ck_q    <= 1'b1;
      num_stage_q   <= NUM_IDLE;
      num_acc_q     <= '0;
      decl_len_q    <= '0;
      len_seen_q    <= 1'b0;
      chunked_q     <= 1'b0;
      remain_q      <= '0;
      closing_q     <= CLS_FIRST;
      last_chunk_q  <= 1'b0;
      total_q       <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      pending_cr_q  <= pending_cr_d;
      line_empty_q  <= line_empty_d;
      after_colon_q <= after_colon_d;
      name_pos_q    <= name_pos_d;
      name_is_len_q <= name_is_len_d;
      name_is_enc_q <= name_is_enc_d;
      value_pos_q   <= value_pos_d;
      value_ck_q    <= value_ck_d;
      num_stage_q   <= num_stage_d;
      num_acc_q     <= num_acc_d;
      decl_len_q    <= decl_len_d;
      len_seen_q    <= len_seen_d;
      chunked_q     <= chunked_d;
      remain_q      <= remain_d;
      closing_q     <= closing_d;
      last_chunk_q  <= last_chunk_d;
      total_q       <= total_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/hrbd_checker.sv
// ---------------------------------------------------------------------------
// hrbd_checker
// Port-level checks for the response body deframer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module hrbd_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic [47:0] m_axis_tdata_o,
  input  wire logic [3:0]  m_axis_tuser_o,
  input  wire logic        m_axis_tlast_o
);
  import hrbd_pkg::*;

  a_body_in_body_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tuser_o[3:1] == PH_BODY))
    else $error("body byte outside body phase");

  a_crlf_err_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[8]) |-> (m_axis_tuser_o[3:1] == PH_CLOSE))
    else $error("crlf error outside chunk close");

  a_end_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tuser_o[3:1] == PH_HEADER || m_axis_tuser_o[3:1] == PH_BODY ||
       m_axis_tuser_o[3:1] == PH_CLOSE))
    else $error("message end in unexpected phase");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled transaction changed");

endmodule

bind http_response_body_deframer hrbd_checker u_hrbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
